// ===== hdl/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime test core.
package tdpt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } tdpt_state_e;

  localparam int unsigned OUT_W        = 8;
  localparam int unsigned SMALL_IDX_W  = 2;
  localparam logic [1:0]  SMALL_LAST   = 2'd3;
  localparam logic [3:0]  FIRST_ODD    = 4'd11;
  localparam logic [3:0]  ODD_STEP     = 4'd2;

  // small primes tried before the odd divisor sweep
  function automatic logic [3:0] small_prime(input logic [SMALL_IDX_W-1:0] idx);
    logic [3:0] p;
    case (idx)
      2'd0:    p = 4'd2;
      2'd1:    p = 4'd3;
      2'd2:    p = 4'd5;
      2'd3:    p = 4'd7;
      default: p = 4'd2;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/tdpt_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module tdpt_divider #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic                  busy_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [VALUE_BITS-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [VALUE_BITS+1:0] diff;

  assign diff = {1'b0, rem_q, quo_q[VALUE_BITS-1]} - {2'b00, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_BITS);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q - CntW'(1);
      busy_d = (cnt_q != CntW'(1));
      if (!diff[VALUE_BITS+1]) begin
        rem_d = diff[VALUE_BITS-1:0];
        quo_d = {quo_q[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[VALUE_BITS-2:0], quo_q[VALUE_BITS-1]};
        quo_d = {quo_q[VALUE_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

`ifndef SYNTHESIS
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with zero count");
  a_rem_lt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) && div_q != '0 |-> rem_q < div_q)
    else $error("remainder not below divisor");
`endif

endmodule

// ===== hdl/trial_division_prime_test_core.sv =====
// Trial-division primality test: top level with sequencer and output register.
//
// Accepts one signed VALUE_BITS-bit integer and returns one item with is_prime.
// Negative values, 0 and 1 skip the divider and go straight to ST_DONE.
// Otherwise the divisors 2, 3, 5 and 7 are tried, then 11, 13, 15, ... while
// divisor <= value / divisor, until one divides the value; each trial runs on
// the single shared radix-2 divider. s_axis_tready_o is high only between items.
module trial_division_prime_test_core #(
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned InW = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [InW-1:0]             s_axis_tdata_i,   // [VALUE_BITS-1:0] value
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [tdpt_pkg::OUT_W-1:0] m_axis_tdata_o    // [0] is_prime
);

  import tdpt_pkg::*;

  tdpt_state_e             state_q, state_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [VALUE_BITS-1:0]   dvs_q, dvs_d;
  logic [SMALL_IDX_W-1:0]  idx_q, idx_d;
  logic                    small_q, small_d;
  logic                    res_q, res_d;
  logic                    out_vld_q, out_vld_d;
  logic                    out_bit_q, out_bit_d;
  logic                    div_start;
  logic                    div_busy;
  logic [VALUE_BITS-1:0]   div_quo;
  logic [VALUE_BITS-1:0]   div_rem;
  logic [VALUE_BITS-1:0]   in_val;
  logic                    in_acc;

  assign in_val = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  tdpt_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (val_q),
    .divisor_i  (dvs_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    dvs_d     = dvs_q;
    idx_d     = idx_q;
    small_d   = small_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    out_bit_d = out_bit_q;
    div_start = 1'b0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          val_d   = in_val;
          dvs_d   = VALUE_BITS'(small_prime('0));
          idx_d   = '0;
          small_d = 1'b1;
          if (in_val[VALUE_BITS-1] || in_val <= VALUE_BITS'(1)) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (small_q) begin
          if (div_rem == '0) begin
            res_d   = (val_q == dvs_q);
            state_d = ST_DONE;
          end else if (idx_q == SMALL_LAST) begin
            small_d = 1'b0;
            dvs_d   = VALUE_BITS'(FIRST_ODD);
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + SMALL_IDX_W'(1);
            dvs_d   = VALUE_BITS'(small_prime(idx_q + SMALL_IDX_W'(1)));
            state_d = ST_LOAD;
          end
        end else begin
          if (dvs_q > div_quo) begin
            res_d   = 1'b1;
            state_d = ST_DONE;
          end else if (div_rem == '0) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            dvs_d   = dvs_q + VALUE_BITS'(ODD_STEP);
            state_d = ST_LOAD;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_bit_d = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      small_q   <= 1'b1;
      idx_q     <= '0;
      dvs_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      small_q   <= small_d;
      idx_q     <= idx_d;
      dvs_q     <= dvs_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    res_q     <= res_d;
    out_bit_q <= out_bit_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_W-1){1'b0}}, out_bit_q};

`ifndef SYNTHESIS
  a_check_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> !div_busy)
    else $error("divider result sampled while busy");
  a_odd_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !small_q && state_q != ST_IDLE && state_q != ST_DONE |-> dvs_q[0])
    else $error("even divisor in odd sweep");
`endif

endmodule

// ===== tb/sv/trial_division_prime_test_core_test.sv =====
// Testbench for trial_division_prime_test_core: directed and random primality checks.
`timescale 1ns / 1ps

module trial_division_prime_test_core_test;

  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned DRAIN_CYC   = 64;
  localparam int unsigned STALL_LIMIT = 4_000_000;
  localparam int unsigned RAND_ITEMS  = 80;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  is_prime;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       s_valid = 1'b0;
  logic                       s_ready;
  logic [VALUE_BITS-1:0]      s_data = '0;
  logic                       m_valid;
  logic                       m_ready = 1'b0;
  logic [tdpt_pkg::OUT_W-1:0] m_data;

  logic [VALUE_BITS-1:0] values_to_send[$];
  verdict_t              verdicts_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_token    = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  int unsigned n_sent        = 0;
  int unsigned n_checked     = 0;
  int unsigned n_primes      = 0;
  int unsigned n_negative    = 0;
  int unsigned errors        = 0;

  always #6 clk_i = ~clk_i;

  trial_division_prime_test_core #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  function automatic logic prime_verdict(logic [VALUE_BITS-1:0] raw);
    longint unsigned v;
    longint unsigned d;
    longint unsigned divs[4];
    divs = '{2, 3, 5, 7};
    v = 64'(raw);
    if (raw[VALUE_BITS-1]) return 1'b0;
    if (v <= 1) return 1'b0;
    foreach (divs[i]) begin
      if (v % divs[i] == 0) return v == divs[i];
    end
    for (d = 11; d <= v / d; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly cheap values; wide ones are negative or carry a small factor
  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] r;
    int unsigned m;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 55) begin
      r = $urandom_range(4095, 0);
    end else if (kind < 68) begin
      r = $urandom_range(65535, 4096);
    end else if (kind < 80) begin
      r = $urandom;
      r[VALUE_BITS-1] = 1'b1;
    end else if (kind < 95) begin
      r = $urandom;
      r[VALUE_BITS-1] = 1'b0;
      case ($urandom_range(3))
        0:       m = 2;
        1:       m = 3;
        2:       m = 5;
        default: m = 7;
      endcase
      r = r - (r % m);
      if (r == 0) r = m * 4;
    end else begin
      r = $urandom_range(12, 0);
    end
    return r;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
    end else begin
      if (s_valid && s_ready) begin
        verdicts_due.push_back('{value: s_data, is_prime: prime_verdict(s_data)});
        n_sent++;
        if (s_data[VALUE_BITS-1]) n_negative++;
      end
      if (!s_valid || s_ready) begin
        if (values_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_valid <= 1'b1;
          s_data  <= values_to_send.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected item: is_prime %0d", m_data[0]);
          errors++;
        end else begin
          verdict_t exp_v;
          exp_v = verdicts_due.pop_front();
          n_checked++;
          if (exp_v.is_prime) n_primes++;
          if (m_data[0] !== exp_v.is_prime) begin
            $error("is_prime mismatch for value %0d: expected %0d, actual %0d",
                   $signed(exp_v.value), exp_v.is_prime, m_data[0]);
            errors++;
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[trial_division_prime_test_core] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic drain_queue();
    while (values_to_send.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_all_done();
    while (values_to_send.size() != 0 || s_valid || verdicts_due.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [VALUE_BITS-1:0] directed[$];
    directed = '{32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 2, 3, 4, 5, 7, 9, 11, 25, 49,
                 121, 143, 169, 1018081, 1000003, 2147483645, 2147483646,
                 2147483647};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 62;
    foreach (directed[i]) values_to_send.push_back(directed[i]);
    wait_all_done();

    for (int i = 0; i < RAND_ITEMS / 3; i++) values_to_send.push_back(random_value());
    drain_queue();

    send_idle_pct = 62;
    recv_idle_pct = 9;
    hold_token++;
    for (int i = 0; i < RAND_ITEMS / 3; i++) values_to_send.push_back(random_value());
    drain_queue();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < RAND_ITEMS - 2 * (RAND_ITEMS / 3); i++)
      values_to_send.push_back(random_value());

    wait_all_done();
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Sent %0d values (%0d negative), checked %0d verdicts, %0d of them prime.",
             n_sent, n_negative, n_checked, n_primes);
    $display("Covered sign and range extremes, small-prime multiples and prime squares.");
    if (errors == 0) begin
      $display("[trial_division_prime_test_core] OK");
    end else begin
      $display("[trial_division_prime_test_core] ERROR");
    end
    $finish;
  end

endmodule
